FILE: src/egp_pkg.sv
// Shared types and constants for the Exp-Golomb bit packer.
// No dependencies; imported by every module of the block.
package egp_pkg;

  localparam int SYMBOL_BITS_DEFAULT = 8;
  localparam int SYM_W     = 8;   // symbol port width
  localparam int CODE_W    = 9;   // v+1 fits in nine bits
  localparam int LEN_W     = 5;   // code length 1..17
  localparam int PEND_W    = 7;   // bits held back between items
  localparam int CNT_W     = 3;   // pending bit count 0..7
  localparam int WIN_W     = 24;  // up to three bytes per item
  localparam int TOT_W     = 5;   // pending + code length 1..24
  localparam int NB_W      = 2;   // bytes per item 0..3
  localparam int QIDX_W    = 1;   // two-entry queue
  localparam int QDEPTH    = 2;

  // One queued job: left-aligned bit window, its byte count, end marker.
  typedef struct packed {
    logic [WIN_W-1:0] bits;
    logic [NB_W-1:0]  nbytes;
    logic             eos;
  } egp_entry_t;

endpackage

FILE: src/egp_front.sv
// Front end: accepts symbols, forms the Exp-Golomb code and merges it with
// the pending bits into a byte window for the queue. Depends on egp_pkg.
module egp_front
  import egp_pkg::*;
#(
  parameter int SYMBOL_BITS = SYMBOL_BITS_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             sym_valid,
  output logic             sym_stall,
  input  logic [SYM_W-1:0] symbol,
  input  logic             end_of_stream,
  input  logic             q_full,
  output logic             push,
  output egp_entry_t       push_entry
);

  localparam int EFF_BITS = (SYMBOL_BITS < SYM_W) ? SYMBOL_BITS : SYM_W;
  localparam logic [SYM_W-1:0] SYM_MASK = SYM_W'((16'd1 << EFF_BITS) - 16'd1);

  logic [PEND_W-1:0] pend_bits;
  logic [CNT_W-1:0]  pend_count;

  logic [CODE_W-1:0] code;
  logic [LEN_W-1:0]  code_len;
  logic [WIN_W-1:0]  acc;
  logic [TOT_W-1:0]  total;
  logic [CNT_W-1:0]  rem;
  logic              pad;
  logic [NB_W-1:0]   nbytes;
  logic [7:0]        rem_mask;
  logic              accept;

  always_comb begin
    code     = CODE_W'(symbol & SYM_MASK) + CODE_W'(1);
    code_len = LEN_W'(1);
    for (int i = 1; i < CODE_W; i++) begin
      if (code[i]) code_len = LEN_W'(2 * i + 1);
    end
    acc      = (WIN_W'(pend_bits) << code_len) | WIN_W'(code);
    total    = TOT_W'(pend_count) + code_len;
    rem      = total[CNT_W-1:0];
    pad      = end_of_stream && (rem != '0);
    nbytes   = total[TOT_W-1:CNT_W] + NB_W'(pad);
    rem_mask = (8'd1 << rem) - 8'd1;
  end

  assign sym_stall         = q_full;
  assign accept            = sym_valid && !q_full;
  assign push              = accept && (nbytes != '0);
  assign push_entry.bits   = acc << (TOT_W'(WIN_W) - total);
  assign push_entry.nbytes = nbytes;
  assign push_entry.eos    = end_of_stream;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_bits  <= '0;
      pend_count <= '0;
    end else if (accept) begin
      if (end_of_stream) begin
        pend_bits  <= '0;
        pend_count <= '0;
      end else begin
        pend_bits  <= acc[PEND_W-1:0] & rem_mask[PEND_W-1:0];
        pend_count <= rem;
      end
    end
  end

`ifndef SYNTHESIS
  // end of stream clears the pending state
  a_eos_clears: assert property (@(posedge clk) disable iff (rst)
    accept && end_of_stream |=> pend_count == '0 && pend_bits == '0)
    else $error("pending state not cleared after end of stream");
  // the last item of a stream always yields a byte
  a_eos_emits: assert property (@(posedge clk) disable iff (rst)
    accept && end_of_stream |-> push)
    else $error("end of stream produced no byte");
`endif

endmodule

FILE: src/egp_queue.sv
// Two-entry queue between front and back ends of the bit packer.
// Depends on egp_pkg.
module egp_queue
  import egp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  egp_entry_t push_entry,
  input  logic       pop,
  output logic       q_full,
  output logic       q_valid,
  output egp_entry_t head
);

  egp_entry_t        entries [QDEPTH];
  logic [QIDX_W-1:0] wr_ptr;
  logic [QIDX_W-1:0] rd_ptr;
  logic [QIDX_W:0]   count;

  assign q_full  = (count == (QIDX_W+1)'(QDEPTH));
  assign q_valid = (count != '0);
  assign head    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QIDX_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QIDX_W'(1);
      count <= count + (QIDX_W+1)'(push) - (QIDX_W+1)'(pop);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_valid)
    else $error("pop from empty queue");
`endif

endmodule

FILE: src/egp_back.sv
// Back end: walks each queued window one byte per beat into the output
// register and marks run and stream ends. Depends on egp_pkg.
module egp_back
  import egp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  egp_entry_t head,
  output logic       pop,
  output logic       byte_valid,
  input  logic       byte_stall,
  output logic [7:0] packed_byte,
  output logic       run_last,
  output logic       stream_done
);

  logic [NB_W-1:0] byte_idx;
  logic            advance;
  logic            last_of_run;
  logic [7:0]      sel_byte;

  assign advance     = !byte_valid || !byte_stall;
  assign last_of_run = (byte_idx + NB_W'(1)) == head.nbytes;
  assign pop         = advance && q_valid && last_of_run;

  always_comb begin
    unique case (byte_idx)
      2'd0:    sel_byte = head.bits[23:16];
      2'd1:    sel_byte = head.bits[15:8];
      default: sel_byte = head.bits[7:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
      byte_idx   <= '0;
    end else if (advance) begin
      byte_valid <= q_valid;
      if (q_valid) byte_idx <= last_of_run ? '0 : byte_idx + NB_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (advance && q_valid) begin
      packed_byte <= sel_byte;
      run_last    <= last_of_run;
      stream_done <= last_of_run && head.eos;
    end
  end

`ifndef SYNTHESIS
  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    byte_valid && stream_done |-> run_last)
    else $error("stream end not on last byte of run");
  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    q_valid |-> byte_idx < head.nbytes)
    else $error("byte index beyond queued run");
`endif

endmodule

FILE: src/exp_golomb_bit_packer.sv
// Top level of the order-0 Exp-Golomb bit packer.
// Depends on egp_pkg, egp_front, egp_queue and egp_back.
//
// Symbol channel (sym_valid / sym_stall): one beat carries a symbol and an
// end_of_stream flag. Each symbol becomes its Exp-Golomb code, packed
// MSB-first behind up to seven bits held from earlier beats.
// Byte channel (byte_valid / byte_stall): one beat per packed byte, first
// code bit in bit 7. run_last marks the last byte caused by one symbol,
// stream_done the final byte of the stream; a trailing partial byte is
// padded with zeros.
// Each byte is written into the queue when its symbol beat is taken, then registered into the output register.
// Throughput: the front takes a symbol every cycle while the two-entry
// queue has room; the back emits one byte per cycle while byte_stall is
// low, one byte after another for a symbol yielding 0 to 3 bytes.
// A stalled receiver holds the output register; the queue fills and then
// sym_stall rises. Reset empties queue and output and clears pending bits.
module exp_golomb_bit_packer
  import egp_pkg::*;
#(
  parameter int SYMBOL_BITS = SYMBOL_BITS_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             sym_valid,
  output logic             sym_stall,
  input  logic [SYM_W-1:0] symbol,
  input  logic             end_of_stream,
  output logic             byte_valid,
  input  logic             byte_stall,
  output logic [7:0]       packed_byte,
  output logic             run_last,
  output logic             stream_done
);

  logic       push;
  egp_entry_t push_entry;
  logic       pop;
  logic       q_full;
  logic       q_valid;
  egp_entry_t head;

  // classify and merge with pending bits
  egp_front #(
    .SYMBOL_BITS (SYMBOL_BITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .sym_valid     (sym_valid),
    .sym_stall     (sym_stall),
    .symbol        (symbol),
    .end_of_stream (end_of_stream),
    .q_full        (q_full),
    .push          (push),
    .push_entry    (push_entry)
  );

  // decouple symbol intake from byte output
  egp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .q_full     (q_full),
    .q_valid    (q_valid),
    .head       (head)
  );

  // emit bytes one beat at a time
  egp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .head        (head),
    .pop         (pop),
    .byte_valid  (byte_valid),
    .byte_stall  (byte_stall),
    .packed_byte (packed_byte),
    .run_last    (run_last),
    .stream_done (stream_done)
  );

endmodule

FILE: tb/egp_stream_checker.sv
// Watches the symbol and byte channels of the Exp-Golomb bit packer.
// Predicts every packed byte and compares the byte beats field by field.
// Depends on egp_pkg for the port widths.
module egp_stream_checker
  import egp_pkg::*;
#(
  parameter int SYMBOL_BITS = SYMBOL_BITS_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             sym_valid,
  input  logic             sym_stall,
  input  logic [SYM_W-1:0] symbol,
  input  logic             end_of_stream,
  input  logic             byte_valid,
  input  logic             byte_stall,
  input  logic [7:0]       packed_byte,
  input  logic             run_last,
  input  logic             stream_done,
  output int               mismatches,
  output int               open_bytes,
  output int               symbols_seen,
  output int               bytes_seen,
  output int               streams_seen
);

  localparam logic [7:0] SYM_MASK = (SYMBOL_BITS >= 8) ? 8'hFF : 8'((1 << SYMBOL_BITS) - 1);

  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       stream_done;
  } byte_beat_t;

  byte_beat_t         expected_bytes[$];
  logic [PEND_W-1:0]  held_bits;
  logic [CNT_W-1:0]   held_count;

  // Encode one symbol, append its bytes to the expectations, advance the held bits.
  function automatic void pack_symbol(input logic [7:0] sym, input logic eos);
    logic [8:0]  code;
    logic [23:0] acc;
    byte_beat_t  beats[3];
    int          n;
    int          len;
    int          total;
    int          cnt;
    code  = {1'b0, sym & SYM_MASK} + 9'd1;
    n     = 0;
    for (int i = 0; i < 9; i++) begin
      if (code[i]) n = i + 1;
    end
    len   = 2 * n - 1;
    acc   = (24'(held_bits) << len) | 24'(code);
    total = int'(held_count) + len;
    cnt   = 0;
    while (total >= 8) begin
      total -= 8;
      beats[cnt] = '{data: acc[total +: 8], run_last: 1'b0, stream_done: 1'b0};
      cnt++;
    end
    acc = acc & ((24'd1 << total) - 24'd1);
    if (eos) begin
      if (total > 0) begin
        beats[cnt] = '{data: 8'(acc << (8 - total)), run_last: 1'b0, stream_done: 1'b0};
        cnt++;
      end
      held_bits  = '0;
      held_count = '0;
    end else begin
      held_bits  = acc[PEND_W-1:0];
      held_count = total[CNT_W-1:0];
    end
    if (cnt > 0) begin
      beats[cnt-1].run_last    = 1'b1;
      beats[cnt-1].stream_done = eos;
    end
    for (int i = 0; i < cnt; i++) expected_bytes.insert(expected_bytes.size(), beats[i]);
  endfunction

  always @(posedge clk) begin
    byte_beat_t want;
    int         bad;
    bad = 0;
    if (rst) begin
      expected_bytes.delete();
      held_bits  = '0;
      held_count = '0;
      mismatches   <= 0;
      symbols_seen <= 0;
      bytes_seen   <= 0;
      streams_seen <= 0;
    end else begin
      if (sym_valid && !sym_stall) begin
        pack_symbol(symbol, end_of_stream);
        symbols_seen <= symbols_seen + 1;
        if (end_of_stream) streams_seen <= streams_seen + 1;
      end
      if (byte_valid && !byte_stall) begin
        bytes_seen <= bytes_seen + 1;
        if (expected_bytes.size() == 0) begin
          $error("byte beat %02h with no expectation waiting", packed_byte);
          bad++;
        end else begin
          want = expected_bytes.pop_front();
          if (packed_byte !== want.data) begin
            $error("packed_byte: expected %02h, got %02h", want.data, packed_byte);
            bad++;
          end
          if (run_last !== want.run_last) begin
            $error("run_last: expected %0b, got %0b", want.run_last, run_last);
            bad++;
          end
          if (stream_done !== want.stream_done) begin
            $error("stream_done: expected %0b, got %0b", want.stream_done, stream_done);
            bad++;
          end
        end
      end
      mismatches <= mismatches + bad;
    end
    open_bytes <= expected_bytes.size();
  end

endmodule

FILE: tb/exp_golomb_bit_packer_tb.sv
// Top of the Exp-Golomb bit packer regression: clock, reset, symbol stimulus,
// byte-side back-pressure and the verdict. Depends on egp_pkg, the packer
// RTL and egp_stream_checker, which does all prediction and comparison.
module exp_golomb_bit_packer_tb;
  import egp_pkg::*;

  localparam int QUIET_LIMIT    = 2000; // cycles with no beat on either side
  localparam int LONG_HOLD      = 48;   // receiver hold-off that fills the queue
  localparam int DIRECTED_COUNT = 18;
  localparam int RANDOM_SYMBOLS = 340;
  localparam int CALM_TAIL      = 60;   // last symbols run with no idling

  // Directed beats as {end_of_stream, symbol}.
  localparam logic [8:0] DIRECTED[DIRECTED_COUNT] = '{
    // end of stream straight after reset: single bit code, padded byte
    {1'b1, 8'd0},
    // codes 00111 and 011 end the stream exactly on a byte boundary
    {1'b0, 8'd6}, {1'b1, 8'd2},
    // seven single-bit codes leave no byte completed, then the longest code
    // on top of seven held bits gives three bytes and an aligned end
    {1'b0, 8'd0}, {1'b0, 8'd0}, {1'b0, 8'd0}, {1'b0, 8'd0},
    {1'b0, 8'd0}, {1'b0, 8'd0}, {1'b0, 8'd0}, {1'b1, 8'd255},
    // field extremes and code-length boundaries
    {1'b0, 8'd255}, {1'b0, 8'd128}, {1'b0, 8'd127}, {1'b0, 8'd1}, {1'b1, 8'd254},
    // short stream ending with a trailing partial byte
    {1'b0, 8'd3}, {1'b1, 8'd0}
  };

  logic             clk = 1'b0;
  logic             rst;
  logic             sym_valid;
  logic             sym_stall;
  logic [SYM_W-1:0] symbol;
  logic             end_of_stream;
  logic             byte_valid;
  logic             byte_stall;
  logic [7:0]       packed_byte;
  logic             run_last;
  logic             stream_done;

  int mismatches;
  int open_bytes;
  int symbols_seen;
  int bytes_seen;
  int streams_seen;

  int symbols_sent;
  bit calm;
  bit long_hold_done;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  exp_golomb_bit_packer dut (
    .clk           (clk),
    .rst           (rst),
    .sym_valid     (sym_valid),
    .sym_stall     (sym_stall),
    .symbol        (symbol),
    .end_of_stream (end_of_stream),
    .byte_valid    (byte_valid),
    .byte_stall    (byte_stall),
    .packed_byte   (packed_byte),
    .run_last      (run_last),
    .stream_done   (stream_done)
  );

  egp_stream_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .sym_valid     (sym_valid),
    .sym_stall     (sym_stall),
    .symbol        (symbol),
    .end_of_stream (end_of_stream),
    .byte_valid    (byte_valid),
    .byte_stall    (byte_stall),
    .packed_byte   (packed_byte),
    .run_last      (run_last),
    .stream_done   (stream_done),
    .mismatches    (mismatches),
    .open_bytes    (open_bytes),
    .symbols_seen  (symbols_seen),
    .bytes_seen    (bytes_seen),
    .streams_seen  (streams_seen)
  );

  // Offer one symbol beat and hold it until the packer takes it. Outside the
  // calm tail, drop valid for a random burst first now and then.
  task automatic send_symbol(input logic [7:0] sym, input logic eos);
    if (!calm && $urandom_range(0, 4) == 0) begin
      sym_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    sym_valid     <= 1'b1;
    symbol        <= sym;
    end_of_stream <= eos;
    do @(posedge clk); while (sym_stall);
    symbols_sent++;
  endtask

  // Symbol side: directed beats, then random streams of random length.
  initial begin
    logic [7:0] sym;
    int         run_len;
    rst           <= 1'b1;
    sym_valid     <= 1'b0;
    symbol        <= '0;
    end_of_stream <= 1'b0;
    calm           = 1'b0;
    symbols_sent   = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIRECTED_COUNT; i++) send_symbol(DIRECTED[i][7:0], DIRECTED[i][8]);

    while (symbols_sent < DIRECTED_COUNT + RANDOM_SYMBOLS) begin
      run_len = $urandom_range(1, 24);
      for (int k = 0; k < run_len; k++) begin
        // bias towards short codes so that many symbols share a byte
        case ($urandom_range(0, 9))
          0, 1, 2: sym = 8'($urandom_range(0, 255));
          3, 4: begin
            case ($urandom_range(0, 3))
              0:       sym = 8'd0;
              1:       sym = 8'd255;
              2:       sym = 8'd127;
              default: sym = 8'd128;
            endcase
          end
          default: sym = 8'($urandom_range(0, 15));
        endcase
        calm = (symbols_sent >= DIRECTED_COUNT + RANDOM_SYMBOLS - CALM_TAIL);
        // the final symbol always closes its stream so the packer is flushed
        send_symbol(sym, (k == run_len - 1) ||
                         (symbols_sent + 1 >= DIRECTED_COUNT + RANDOM_SYMBOLS));
        if (symbols_sent >= DIRECTED_COUNT + RANDOM_SYMBOLS) break;
      end
    end
    sym_valid <= 1'b0;

    // let the checker register the last beat, then drain the byte side
    @(posedge clk);
    while (open_bytes != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Run covered %0d symbols in %0d streams and %0d byte beats,",
             symbols_seen, streams_seen, bytes_seen);
    $display("with random idling on both channels and one long receiver hold-off.");
    if (mismatches == 0 && open_bytes == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Byte side: random stall bursts, runs with no stall, and one long hold-off
  // while symbols keep coming so that the queue fills and sym_stall rises.
  initial begin
    long_hold_done = 1'b0;
    byte_stall <= 1'b0;
    @(negedge rst);
    forever begin
      if (calm) begin
        byte_stall <= 1'b0;
        @(posedge clk);
      end else if (!long_hold_done && symbols_sent >= 40) begin
        byte_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_done = 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
        byte_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        byte_stall <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // Watchdog: end the run if no beat moves on either channel for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((sym_valid && !sym_stall) || (byte_valid && !byte_stall)) quiet = 0;
      else quiet++;
    end
    $display("Timed out after %0d cycles with no beat accepted.", QUIET_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: files.f
src/egp_pkg.sv
src/egp_front.sv
src/egp_queue.sv
src/egp_back.sv
src/exp_golomb_bit_packer.sv
tb/egp_stream_checker.sv
tb/exp_golomb_bit_packer_tb.sv
